@@ hw/rtl/fbc_pkg.sv @@
package fbc_pkg;

	localparam int KEY_BITS = 80;
	localparam int SUBKEY_BITS = 96;

	localparam logic [1:0] REG_KEY_UPPER = 2'd0;
	localparam logic [1:0] REG_KEY_LOWER = 2'd1;
	localparam logic [1:0] REG_DECRYPT = 2'd2;

	typedef struct packed {
		logic [63:0] blk;
		logic        dec;
	} fbc_stage_t;

	localparam logic [7:0] SBOX [256] = '{
		8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
		8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
		8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
		8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
		8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
		8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
		8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
		8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
		8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
		8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
		8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
		8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
		8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
		8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
		8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
		8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
	};

	function automatic logic [15:0] g_mix(input logic [15:0] w, input logic [31:0] k);
		logic [7:0] g2, g3, g4, g5;
		g2 = SBOX[w[7:0] ^ k[7:0]] ^ w[15:8];
		g3 = SBOX[g2 ^ k[15:8]] ^ w[7:0];
		g4 = SBOX[g3 ^ k[23:16]] ^ g2;
		g5 = SBOX[g4 ^ k[31:24]] ^ g3;
		return {g4, g5};
	endfunction

	// Subkey byte i of round r: the key rotated left by 12r+i+1 bits, byte (4r + i mod 4) mod 10.
	function automatic logic [7:0] key_byte(input logic [KEY_BITS-1:0] key, input int r,
		input int i);
		int s;
		int n;
		int b;
		logic [7:0] res;
		s = (12 * r + i + 1) % KEY_BITS;
		n = (4 * r + i % 4) % 10;
		for (int j = 0; j < 8; j++) begin
			b = (8 * n + j - s + KEY_BITS) % KEY_BITS;
			res[j] = key[b[6:0]];
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/fbc_round.sv @@
module fbc_round import fbc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	output logic                   up_ready,
	input  fbc_stage_t             up_data,
	input  logic [SUBKEY_BITS-1:0] subkey_enc,
	input  logic [SUBKEY_BITS-1:0] subkey_dec,
	output logic                   dn_valid,
	input  logic                   dn_ready,
	output fbc_stage_t             dn_data
);

	logic             valid_s1;
	fbc_stage_t       data_s1;
	logic [SUBKEY_BITS-1:0] sk;
	logic [15:0]      t0, t1, f0, f1;
	fbc_stage_t       next_data;

	always_comb begin
		sk = up_data.dec ? subkey_dec : subkey_enc;
		t0 = g_mix(up_data.blk[63:48], sk[31:0]);
		t1 = g_mix(up_data.blk[47:32], sk[63:32]);
		f0 = t0 + {t1[14:0], 1'b0} + {sk[71:64], sk[79:72]};
		f1 = {t0[14:0], 1'b0} + t1 + {sk[87:80], sk[95:88]};
		next_data.blk = {up_data.blk[31:16] ^ f0, up_data.blk[15:0] ^ f1,
			up_data.blk[63:48], up_data.blk[47:32]};
		next_data.dec = up_data.dec;
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= next_data;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data = data_s1;

endmodule

@@ hw/rtl/feistel_block_cipher_64_top.sv @@
// An input passes one register stage for whitening, then one per round, to its result.
// Throughput: one block per cycle while result_ready does not stall the pipeline.
// Each round stage is set by four dependent table lookups and a three-term 16-bit add.
// Reset clears all valid bits and the key and mode registers to zero.
module feistel_block_cipher_64_top import fbc_pkg::*; #(
	parameter int ROUND_COUNT = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [63:0] data_block,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [63:0] result_block
);

	logic [63:0] key_upper_q;
	logic [15:0] key_lower_q;
	logic        decrypt_q;
	logic        cfg_write;
	logic [KEY_BITS-1:0] key80;

	logic       st_valid [ROUND_COUNT+1];
	logic       st_ready [ROUND_COUNT+1];
	fbc_stage_t st_data  [ROUND_COUNT+1];
	logic [SUBKEY_BITS-1:0] sk_enc [ROUND_COUNT];
	logic [SUBKEY_BITS-1:0] sk_dec [ROUND_COUNT];

	logic       valid_s0;
	fbc_stage_t data_s0;
	logic [63:0] last;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
			decrypt_q <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[4:3])
				REG_KEY_UPPER: key_upper_q <= pwdata;
				REG_KEY_LOWER: key_lower_q <= pwdata[15:0];
				REG_DECRYPT:   decrypt_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_KEY_UPPER: prdata = key_upper_q;
			REG_KEY_LOWER: prdata = {48'd0, key_lower_q};
			REG_DECRYPT:   prdata = {63'd0, decrypt_q};
			default:       prdata = '0;
		endcase
	end

	assign key80 = {key_upper_q, key_lower_q};

	assign data_ready = !valid_s0 || st_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (data_ready) begin
			valid_s0 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			data_s0.blk <= data_block ^ key_upper_q;
			data_s0.dec <= decrypt_q;
		end
	end

	assign st_valid[0] = valid_s0;
	assign st_data[0] = data_s0;

	for (genvar p = 0; p < ROUND_COUNT; p++) begin : g_round
		for (genvar i = 0; i < 12; i++) begin : g_byte
			assign sk_enc[p][8*i +: 8] = key_byte(key80, p, i);
			assign sk_dec[p][8*i +: 8] = key_byte(key80, ROUND_COUNT - 1 - p, i);
		end

		fbc_round u_round (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (st_valid[p]),
			.up_ready   (st_ready[p]),
			.up_data    (st_data[p]),
			.subkey_enc (sk_enc[p]),
			.subkey_dec (sk_dec[p]),
			.dn_valid   (st_valid[p+1]),
			.dn_ready   (st_ready[p+1]),
			.dn_data    (st_data[p+1])
		);
	end

	assign st_ready[ROUND_COUNT] = result_ready;
	assign result_valid = st_valid[ROUND_COUNT];
	assign last = st_data[ROUND_COUNT].blk;
	assign result_block = {last[31:0], last[63:32]} ^ key_upper_q;

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && data_ready |=> valid_s0)
		else $error("Accepted transfer did not reach the first stage.");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s0 |-> data_ready)
		else $error("Empty first stage refused a transfer.");

	a_mode_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && paddr[4:3] == REG_DECRYPT |=> decrypt_q == $past(pwdata[0]))
		else $error("Mode register write was lost.");

endmodule
